@@ rtl/prab_pkg.sv @@
package prab_pkg;

    // request field widths
    localparam int SIZE_W  = 23;
    localparam int FPAGE_W = 10;

    // result field widths
    localparam int STATUS_W = 2;
    localparam int SPAGE_W  = 10;
    localparam int FREED_W  = 11;

    // width of the rounded-up numerator and quotient of the page division
    localparam int NUM_W = SIZE_W + 1;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // placement modes
    localparam logic MODE_NEXT_FIT = 1'b0;
    localparam logic MODE_BEST_FIT = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 2'd0,
        ST_FAILED    = 2'd1,
        ST_FREED     = 2'd2
    } status_t;

endpackage

@@ rtl/page_run_allocator_next_best_fit.sv @@
// channel   | signals                              | timing
// ----------+--------------------------------------+-------------------------------------
// request   | start, busy, kind, size_bytes,       | taken at a clock edge with start high
//           | free_page                            | and busy low
// result    | done, status, start_page,            | one result per request, done high for
//           | pages_freed                          | a single cycle, cannot be stalled
// config    | cfg_we, cfg_wdata                    | placement mode written on cfg_we
//
// allocate: page rounding in S_DIV (multiply by the reciprocal of PAGE_BYTES), set-up in S_SCAN_RD,
//   a scan of up to NUM_PAGES pages (next fit) or of all pages then S_BEST_END (best fit), one page
//   a cycle through the map's read port, then S_MARK writes each page of the run
// free: S_FREE_RD checks free_page, then S_FREE_CHK examines pages upward from it, at most pages released + 1
// the result strobe follows the last working cycle with busy low; the receiver cannot stall it
// after reset S_CLEAR clears every page of the map with busy high; mode writes still land
module page_run_allocator_next_best_fit
    import prab_pkg::*;
#(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_BYTES = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                start,
    output logic                busy,
    input  logic                kind,
    input  logic [SIZE_W-1:0]   size_bytes,
    input  logic [FPAGE_W-1:0]  free_page,

    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [SPAGE_W-1:0]  start_page,
    output logic [FREED_W-1:0]  pages_freed,

    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    // page index width and a count width that can hold NUM_PAGES itself
    localparam int PW = $clog2(NUM_PAGES);
    localparam int CW = PW + 1;

    // reciprocal of PAGE_BYTES, rounded up; exact floor for any NUM_W-bit numerator
    localparam int     PB_LOG   = $clog2(PAGE_BYTES);
    localparam int     RECIP_SH = NUM_W + PB_LOG;
    localparam int     MW       = NUM_W + 1;
    localparam int     PRODW    = NUM_W + MW;
    localparam longint RECIP_L  =
        ((longint'(1) << RECIP_SH) + longint'(PAGE_BYTES - 1)) / longint'(PAGE_BYTES);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    localparam logic [PW-1:0] LAST_PAGE = PW'(NUM_PAGES - 1);
    localparam logic [CW-1:0] PAGES_C   = CW'(NUM_PAGES);

    // one-hot sequencer states
    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_DIV      = 9'b000000100,
        S_SCAN_RD  = 9'b000001000,
        S_SCAN     = 9'b000010000,
        S_BEST_END = 9'b000100000,
        S_MARK     = 9'b001000000,
        S_FREE_RD  = 9'b010000000,
        S_FREE_CHK = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // page map: {used, owner} per page
    logic [PW:0] map_mem [NUM_PAGES];
    logic [PW:0] rd_data_reg;
    logic [PW-1:0] rd_addr;
    logic          map_we;
    logic [PW-1:0] map_waddr;
    logic [PW:0]   map_wdata;

    // latched request
    logic                kind_reg,   kind_next;
    logic [FPAGE_W-1:0]  fpage_reg,  fpage_next;

    // page rounding
    logic [NUM_W-1:0]    num_reg,    num_next;

    // scan, mark and free working registers
    logic [CW-1:0]       n_reg,      n_next;
    logic [PW-1:0]       cur_reg,    cur_next;
    logic [CW-1:0]       left_reg,   left_next;
    logic [CW-1:0]       cnt_reg,    cnt_next;
    logic [PW-1:0]       rstart_reg, rstart_next;
    logic [CW-1:0]       blen_reg,   blen_next;
    logic [PW-1:0]       bstart_reg, bstart_next;
    logic                found_reg,  found_next;
    logic [PW-1:0]       astart_reg, astart_next;

    // architectural state
    logic [CW-1:0]       ptr_reg,    ptr_next;
    logic                mode_reg;

    // result registers
    logic                done_reg,   done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SPAGE_W-1:0]  spage_reg,  spage_next;
    logic [FREED_W-1:0]  freed_reg,  freed_next;

    // combinational helpers
    logic              used;
    logic [PW-1:0]     owner;
    logic [PW-1:0]     cur_inc;
    logic [PW-1:0]     cur_wrap;
    logic [CW-1:0]     cnt_eff;
    logic [CW-1:0]     cnt_inc;
    logic [PRODW-1:0]  prod;
    logic [NUM_W-1:0]  quot;
    logic              cand;
    logic [PW-1:0]     fp_idx;
    logic              fp_in_range;
    logic [PW-1:0]     nf_start;

    assign used        = rd_data_reg[PW];
    assign owner       = rd_data_reg[PW-1:0];
    assign cur_inc     = cur_reg + PW'(1);
    assign cur_wrap    = (cur_reg == LAST_PAGE) ? '0 : cur_inc;
    // next-fit: the count starts afresh when the scan wraps to page 0
    assign cnt_eff     = (cur_reg == '0) ? '0 : cnt_reg;
    assign cnt_inc     = cnt_eff + CW'(1);
    assign nf_start    = PW'(CW'(cur_reg) + CW'(1) - n_reg);
    // best-fit candidate check on the run just closed
    assign cand        = (cnt_reg >= n_reg) && (!found_reg || (cnt_reg < blen_reg));
    assign fp_idx      = PW'(fpage_reg);
    assign fp_in_range = (32'(fpage_reg) < 32'(NUM_PAGES));

    // rounded-up page count in one multiply
    assign prod = PRODW'(num_reg) * PRODW'(RECIP);
    assign quot = NUM_W'(prod >> RECIP_SH);

    // page map port, registered read
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        rd_data_reg <= map_mem[rd_addr];
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        fpage_next  = fpage_reg;
        num_next    = num_reg;
        n_next      = n_reg;
        cur_next    = cur_reg;
        left_next   = left_reg;
        cnt_next    = cnt_reg;
        rstart_next = rstart_reg;
        blen_next   = blen_reg;
        bstart_next = bstart_reg;
        found_next  = found_reg;
        astart_next = astart_reg;
        ptr_next    = ptr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        spage_next  = spage_reg;
        freed_next  = freed_reg;
        rd_addr     = cur_reg;
        map_we      = 1'b0;
        map_waddr   = cur_reg;
        map_wdata   = '0;

        case (state_reg)
            S_CLEAR:
            begin
                map_we   = 1'b1;
                cur_next = cur_inc;
                if (cur_reg == LAST_PAGE)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    fpage_next = free_page;
                    num_next   = NUM_W'(size_bytes) + NUM_W'(PAGE_BYTES - 1);
                    if (kind == KIND_FREE)
                    begin
                        state_next = S_FREE_RD;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                // zero pages or more than the heap holds fail at once
                if ((quot == '0) || (quot > NUM_W'(NUM_PAGES)))
                begin
                    done_next   = 1'b1;
                    status_next = ST_FAILED;
                    spage_next  = '0;
                    freed_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    n_next     = CW'(quot);
                    state_next = S_SCAN_RD;
                end
            end

            S_SCAN_RD:
            begin
                if ((mode_reg == MODE_NEXT_FIT) && (ptr_reg < PAGES_C))
                begin
                    rd_addr  = PW'(ptr_reg);
                    cur_next = PW'(ptr_reg);
                end
                else
                begin
                    rd_addr  = '0;
                    cur_next = '0;
                end
                left_next  = PAGES_C;
                cnt_next   = '0;
                found_next = 1'b0;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (mode_reg == MODE_NEXT_FIT)
                begin
                    cnt_next = used ? '0 : cnt_inc;
                    if (!used && (cnt_inc == n_reg))
                    begin
                        astart_next = nf_start;
                        cur_next    = nf_start;
                        left_next   = n_reg;
                        ptr_next    = CW'(nf_start) + n_reg;
                        state_next  = S_MARK;
                    end
                    else if (left_reg == CW'(1))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FAILED;
                        spage_next  = '0;
                        freed_next  = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        rd_addr   = cur_wrap;
                        cur_next  = cur_wrap;
                        left_next = left_reg - CW'(1);
                    end
                end
                else
                begin
                    if (!used)
                    begin
                        if (cnt_reg == '0)
                        begin
                            rstart_next = cur_reg;
                        end
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        if (cand)
                        begin
                            found_next  = 1'b1;
                            blen_next   = cnt_reg;
                            bstart_next = rstart_reg;
                        end
                        cnt_next = '0;
                    end
                    if (cur_reg == LAST_PAGE)
                    begin
                        state_next = S_BEST_END;
                    end
                    else
                    begin
                        rd_addr  = cur_inc;
                        cur_next = cur_inc;
                    end
                end
            end

            S_BEST_END:
            begin
                // close the run that reaches the top of the heap
                if (cand)
                begin
                    astart_next = rstart_reg;
                    cur_next    = rstart_reg;
                    left_next   = n_reg;
                    ptr_next    = CW'(rstart_reg) + n_reg;
                    state_next  = S_MARK;
                end
                else if (found_reg)
                begin
                    astart_next = bstart_reg;
                    cur_next    = bstart_reg;
                    left_next   = n_reg;
                    ptr_next    = CW'(bstart_reg) + n_reg;
                    state_next  = S_MARK;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_FAILED;
                    spage_next  = '0;
                    freed_next  = '0;
                    state_next  = S_IDLE;
                end
            end

            S_MARK:
            begin
                map_we    = 1'b1;
                map_wdata = {1'b1, astart_reg};
                cur_next  = cur_inc;
                left_next = left_reg - CW'(1);
                if (left_reg == CW'(1))
                begin
                    done_next   = 1'b1;
                    status_next = ST_ALLOCATED;
                    spage_next  = SPAGE_W'(astart_reg);
                    freed_next  = '0;
                    state_next  = S_IDLE;
                end
            end

            S_FREE_RD:
            begin
                cnt_next = '0;
                if (fp_in_range)
                begin
                    rd_addr    = fp_idx;
                    cur_next   = fp_idx;
                    state_next = S_FREE_CHK;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_FREED;
                    spage_next  = '0;
                    freed_next  = '0;
                    state_next  = S_IDLE;
                end
            end

            S_FREE_CHK:
            begin
                rd_addr = cur_inc;
                if (used && (owner == fp_idx))
                begin
                    map_we    = 1'b1;
                    map_wdata = {1'b0, cur_reg};
                    cnt_next  = cnt_reg + CW'(1);
                    cur_next  = cur_inc;
                    if (cur_reg == LAST_PAGE)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FREED;
                        spage_next  = '0;
                        freed_next  = FREED_W'(cnt_reg + CW'(1));
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_FREED;
                    spage_next  = '0;
                    freed_next  = FREED_W'(cnt_reg);
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cur_reg   <= '0;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
            mode_reg  <= MODE_NEXT_FIT;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            ptr_reg   <= ptr_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        fpage_reg  <= fpage_next;
        num_reg    <= num_next;
        n_reg      <= n_next;
        left_reg   <= left_next;
        cnt_reg    <= cnt_next;
        rstart_reg <= rstart_next;
        blen_reg   <= blen_next;
        bstart_reg <= bstart_next;
        found_reg  <= found_next;
        astart_reg <= astart_next;
        status_reg <= status_next;
        spage_reg  <= spage_next;
        freed_reg  <= freed_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign start_page  = spage_reg;
    assign pages_freed = freed_reg;

`ifndef SYNTHESIS
    // a result is only shown once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");

    // a taken request always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // roving pointer never goes past the top of the heap (it may equal NUM_PAGES)
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PAGES_C)
        else $error("roving pointer beyond heap");

    // marking never runs with no pages left to write
    a_mark_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> (left_reg != '0))
        else $error("mark with zero pages left");

    // kind of a finished request matches its status
    a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ((kind_reg == KIND_FREE) == (status_reg == ST_FREED)))
        else $error("status does not match request kind");
`endif

endmodule
